/* design/sacl_pkg.sv */
// shared types and constants for the tag cache model
`timescale 1ns / 1ps
package sacl_pkg;
   localparam int CNT_W = 40;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] WT_WRITE_BYTES = 40'd4;
   // associativity code for a single fully associative set
   localparam logic [1:0] ASSOC_FULL = 2'd3;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_ASSOC = 2'd0,
      REG_WBACK = 2'd1,
      REG_BLOG  = 2'd2,
      REG_CLOG  = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEARCH,
      ST_VICTIM,
      ST_UPDATE,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // saturating add on counters
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = (s[CNT_W] || s[CNT_W-1:0] == CNT_MAX) ? CNT_MAX : s[CNT_W-1:0];
   endfunction
endpackage

/* design/set_assoc_cache_lru_model.sv */
// Tag-only LRU cache model: top level with access sequencer and counters
// A read or write searches the ways of its set one at a time and, on a miss,
// then replaces a victim; a flush reads every line and counts the dirty ones.
// Only one request is in flight at a time; the way search over the line memory sets its pace.
// Reset (and any config write) clears counters and runs a clearing pass over
// LINES line entries, one per cycle, during which no request is accepted.
`timescale 1ns / 1ps
module set_assoc_cache_lru_model
   import sacl_pkg::*;
#(
   parameter int LINES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // op[1:0], address[33:2], zero[39:34]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [167:0] rsp_tdata,   // hit[0], access_total[40:1], hit_total[80:41],
                                     // bytes_fetched[120:81], bytes_written[160:121],
                                     // zero[167:161]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   localparam int LLOG_MAX = $clog2(LINES + 1) - 1;
   localparam int AW = (LLOG_MAX < 1) ? 1 : LLOG_MAX;
   localparam int CW = AW + 1;

   state_type state_ff, state_in;
   logic [1:0]  assoc_ff;
   logic        wback_ff;
   logic [3:0]  blog_ff;
   logic [4:0]  clog_ff;
   logic [CNT_W-1:0] acc_ff, acc_in, hitc_ff, hitc_in, fet_ff, fet_in, wrb_ff, wrb_in;
   logic        hit_ff, hit_in;
   logic        is_wr_ff, is_wr_in;
   logic [31:0] tag_ff, tag_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW-1:0] cnt_ff, cnt_in;       // ways or lines issued
   logic [CW-1:0] seen_ff, seen_in;     // entries compared
   logic [CW-1:0] nway_ff, nway_in;
   logic        inv_ff, inv_in;
   logic [AW-1:0] vic_ff, vic_in;
   logic [39:0] vic_lu_ff, vic_lu_in;
   logic        vic_dirty_ff, vic_dirty_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [167:0] rsp_d_ff, rsp_d_in;

   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra, rd_idx_ff, rd_idx_in;
   logic [73:0] mem_wd, mem_rd;
   logic        rd_valid_ff, rd_valid_in;

   // geometry
   logic [4:0] llog, wlog, slog;
   logic [1:0] op_w;
   logic [31:0] addr_w, set_w;
   logic [5:0] bs;
   always_comb begin
      llog = (clog_ff > {1'b0, blog_ff}) ? clog_ff - {1'b0, blog_ff} : 5'd0;
      if (llog > 5'(LLOG_MAX)) llog = 5'(LLOG_MAX);
      wlog = (assoc_ff == ASSOC_FULL) ? llog : {3'b0, assoc_ff};
      if (wlog > llog) wlog = llog;
      slog = llog - wlog;
      op_w = req_tdata[1:0];
      addr_w = req_tdata[33:2];
      set_w = (addr_w >> blog_ff) & ((32'd1 << slog) - 32'd1);
      bs = {2'b0, blog_ff} + {1'b0, slog};
   end

   logic [CNT_W-1:0] block_w;
   assign block_w = CNT_W'(1) << blog_ff;

   logic        r_valid, r_dirty;
   logic [31:0] r_tag;
   logic [39:0] r_lu;
   assign {r_valid, r_dirty, r_tag, r_lu} = mem_rd;

   sacl_line_mem #(.LINES(LINES), .AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   // a pending config write takes precedence over a request
   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         assoc_ff <= 2'd0;
         wback_ff <= 1'b1;
         blog_ff  <= 4'd4;
         clog_ff  <= 5'd10;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ASSOC: assoc_ff <= csr_data[1:0];
            REG_WBACK: wback_ff <= csr_data[0];
            REG_BLOG:  blog_ff  <= csr_data[3:0];
            REG_CLOG:  clog_ff  <= csr_data[4:0];
            default:   assoc_ff <= assoc_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         rsp_v_ff <= 1'b0;
         acc_ff <= '0; hitc_ff <= '0; fet_ff <= '0; wrb_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rsp_v_ff <= rsp_v_in;
         acc_ff <= acc_in; hitc_ff <= hitc_in; fet_ff <= fet_in; wrb_ff <= wrb_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff <= hit_in; is_wr_ff <= is_wr_in; tag_ff <= tag_in; base_ff <= base_in;
      seen_ff <= seen_in; nway_ff <= nway_in; inv_ff <= inv_in; vic_ff <= vic_in;
      vic_lu_ff <= vic_lu_in; vic_dirty_ff <= vic_dirty_in; dcnt_ff <= dcnt_in;
      rsp_d_ff <= rsp_d_in; rd_idx_ff <= rd_idx_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      acc_in = acc_ff; hitc_in = hitc_ff; fet_in = fet_ff; wrb_in = wrb_ff;
      hit_in = hit_ff; is_wr_in = is_wr_ff; tag_in = tag_ff; base_in = base_ff;
      seen_in = seen_ff; nway_in = nway_ff; inv_in = inv_ff; vic_in = vic_ff;
      vic_lu_in = vic_lu_ff; vic_dirty_in = vic_dirty_ff; dcnt_in = dcnt_ff;
      rd_idx_in = rd_idx_ff; rd_valid_in = 1'b0;
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;

      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               acc_in = '0; hitc_in = '0; fet_in = '0; wrb_in = '0;
               cnt_in = '0;
               state_in = ST_CLEAR;
            end else if (req_tvalid && req_tready) begin
               hit_in = 1'b0; cnt_in = '0; seen_in = '0;
               nway_in = CW'(1) << wlog;
               inv_in = 1'b0; vic_dirty_in = 1'b0; dcnt_in = '0;
               is_wr_in = (op_w == OP_WRITE);
               tag_in = 32'((33'(addr_w)) >> bs);
               base_in = AW'(set_w << wlog);
               if (op_w == OP_READ || op_w == OP_WRITE) begin
                  acc_in = sat_add(acc_ff, 40'd1);
                  if (op_w == OP_WRITE && !wback_ff)
                     wrb_in = sat_add(wrb_ff, WT_WRITE_BYTES);
                  state_in = ST_SEARCH;
               end else if (op_w == OP_FLUSH) begin
                  nway_in = CW'(1) << llog;
                  base_in = '0;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(LINES - 1)) state_in = ST_IDLE;
         end
         ST_SEARCH, ST_FLUSH: begin
            // issue one read a cycle, compare the returning one
            if (cnt_ff < nway_ff) begin
               mem_ra = base_ff + cnt_ff[AW-1:0];
               rd_idx_in = mem_ra;
               rd_valid_in = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               seen_in = seen_ff + CW'(1);
               if (state_ff == ST_FLUSH) begin
                  if (r_dirty) dcnt_in = dcnt_ff + CNT_W'(1);
                  if (seen_in == nway_ff) begin
                     wrb_in = sat_add(wrb_ff, CNT_W'(dcnt_in << blog_ff));
                     state_in = ST_DONE;
                  end
               end else if (r_valid && r_tag == tag_ff) begin
                  hit_in = 1'b1;
                  hitc_in = sat_add(hitc_ff, 40'd1);
                  mem_we = 1'b1; mem_wa = rd_idx_ff;
                  mem_wd = {1'b1, r_dirty | (is_wr_ff & wback_ff), r_tag, acc_ff};
                  rd_valid_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // victim tracking: first invalid, else smallest last use
                  if (!inv_ff) begin
                     if (!r_valid) begin
                        inv_in = 1'b1; vic_in = rd_idx_ff; vic_dirty_in = r_dirty;
                     end else if (seen_ff == '0 || r_lu < vic_lu_ff) begin
                        vic_in = rd_idx_ff; vic_lu_in = r_lu; vic_dirty_in = r_dirty;
                     end
                  end
                  if (seen_in == nway_ff) state_in = ST_VICTIM;
               end
            end
         end
         ST_VICTIM: begin
            fet_in = sat_add(fet_ff, block_w);
            if (vic_dirty_ff) wrb_in = sat_add(wrb_ff, block_w);
            mem_we = 1'b1; mem_wa = vic_ff;
            mem_wd = {1'b1, is_wr_ff & wback_ff, tag_ff, acc_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_v_in = 1'b1;
            rsp_d_in = {7'b0, wrb_ff, fet_ff, hitc_ff, acc_ff, hit_ff};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> !req_tready) else $error("request taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> mem_we) else $error("clearing pass skipped a line");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_v_ff) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      (hitc_ff <= acc_ff)) else $error("hit count above access count");
endmodule

/* design/sacl_line_mem.sv */
// line state memory: valid, dirty, tag and last use per line, registered read
`timescale 1ns / 1ps
module sacl_line_mem
   import sacl_pkg::*;
#(
   parameter int LINES = 256,
   parameter int AW = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [73:0]       wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [73:0]       rd_data
);
   // {valid, dirty, tag[31:0], last_use[39:0]}
   logic [73:0] mem [LINES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* dv/tb_top.sv */
// testbench for the tag cache model: directed and random access traffic checked against a predictor
`timescale 1ns / 1ps
module tb_top;
   import sacl_pkg::*;

   localparam int NLINES = 256;
   localparam int CMAX = 40;

   typedef struct packed {
      op_type      op;
      logic [31:0] addr;
   } access_req;

   // first field in the highest bits, matching the response packing
   typedef struct packed {
      logic [CMAX-1:0] written;
      logic [CMAX-1:0] fetched;
      logic [CMAX-1:0] hits;
      logic [CMAX-1:0] acc;
      logic            hit;
   } cache_rsp;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [167:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   set_assoc_cache_lru_model #(.LINES(NLINES)) dut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [1:0]      cfg_assoc;
   logic            cfg_wb;
   logic [3:0]      cfg_blog;
   logic [4:0]      cfg_clog;
   logic            m_valid [NLINES];
   logic            m_dirty [NLINES];
   logic [31:0]     m_tag [NLINES];
   logic [CMAX-1:0] m_use [NLINES];
   logic [CMAX-1:0] n_acc, n_hit, n_fetch, n_write;

   access_req pending_reqs[$];
   cache_rsp  expected_rsps[$];
   int  fail_count = 0;
   int  sent_count = 0;
   int  got_count = 0;
   bit  quiet = 0;
   bit  tx_hold = 0;
   int  tx_gap = 0, rx_gap = 0;
   longint cycles = 0;

   function automatic logic [CMAX-1:0] csat(logic [CMAX-1:0] a, logic [CMAX-1:0] b);
      logic [CMAX:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s[CMAX] || s[CMAX-1:0] == {CMAX{1'b1}}) ? {CMAX{1'b1}} : s[CMAX-1:0];
   endfunction

   function automatic void clear_cache();
      for (int i = 0; i < NLINES; i++) begin
         m_valid[i] = 0; m_dirty[i] = 0; m_tag[i] = '0; m_use[i] = '0;
      end
      n_acc = '0; n_hit = '0; n_fetch = '0; n_write = '0;
   endfunction

   // expected response for one access
   function automatic cache_rsp predict_access(access_req r);
      cache_rsp e;
      int llog, wlog, slog, ways, base, vic, maxlog;
      logic [CMAX-1:0] blk;
      logic [31:0] set_idx, tg;
      bit found, inval, wr;
      int nl, nd;
      maxlog = $clog2(NLINES);
      blk = 40'd1 << cfg_blog;
      llog = (cfg_clog > cfg_blog) ? cfg_clog - cfg_blog : 0;
      if (llog > maxlog) llog = maxlog;
      wlog = (cfg_assoc == ASSOC_FULL) ? llog : cfg_assoc;
      if (wlog > llog) wlog = llog;
      slog = llog - wlog;
      ways = 1 << wlog;
      found = 0;
      wr = (r.op == OP_WRITE);
      if (r.op == OP_FLUSH) begin
         nl = 1 << llog;
         nd = 0;
         for (int i = 0; i < nl; i++) if (m_dirty[i]) nd++;
         n_write = csat(n_write, blk * nd);
      end else if (r.op != OP_NOP) begin
         if (wr && !cfg_wb) n_write = csat(n_write, WT_WRITE_BYTES);
         set_idx = (r.addr >> cfg_blog) & ((32'd1 << slog) - 1);
         tg = 32'(64'(r.addr) >> (cfg_blog + slog));
         base = set_idx << wlog;
         n_acc = csat(n_acc, 1);
         for (int w = 0; w < ways && !found; w++) begin
            if (m_valid[base+w] && m_tag[base+w] == tg) begin
               found = 1;
               m_use[base+w] = n_acc;
               if (wr && cfg_wb) m_dirty[base+w] = 1;
               n_hit = csat(n_hit, 1);
            end
         end
         if (!found) begin
            n_fetch = csat(n_fetch, blk);
            vic = base;
            inval = 0;
            for (int w = 0; w < ways && !inval; w++)
               if (!m_valid[base+w]) begin vic = base + w; inval = 1; end
            if (!inval)
               for (int w = 1; w < ways; w++)
                  if (m_use[base+w] < m_use[vic]) vic = base + w;
            if (m_dirty[vic]) n_write = csat(n_write, blk);
            m_valid[vic] = 1; m_tag[vic] = tg; m_use[vic] = n_acc;
            m_dirty[vic] = wr && cfg_wb;
         end
      end
      e.hit = found; e.acc = n_acc; e.hits = n_hit;
      e.fetched = n_fetch; e.written = n_write;
      return e;
   endfunction

   // driver: presents pending requests
   always @(negedge clock) begin
      if (!reset) begin
         if (tx_gap > 0) tx_gap--;
         else if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 15);
         if (pending_reqs.size() > 0 && tx_gap == 0 && !tx_hold) begin
            req_tvalid <= 1;
            req_tdata <= {6'd0, pending_reqs[0].addr, pending_reqs[0].op};
         end else
            req_tvalid <= 0;
         if (rx_gap > 0) rx_gap--;
         else if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 15);
         rsp_tready <= (rx_gap == 0);
      end
   end

   // dequeue and prediction at the accepting edge
   always @(posedge clock) begin
      cache_rsp p;
      cycles++;
      if (!reset && req_tvalid && req_tready) begin
         void'(pending_reqs.pop_front());
         sent_count++;
         p = predict_access(access_req'({req_tdata[1:0], req_tdata[33:2]}));
         expected_rsps = {expected_rsps, p};
      end
   end

   // monitor: compares each response with the oldest expectation
   always @(posedge clock) begin
      cache_rsp a, e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = cache_rsp'(rsp_tdata[160:0]);
         got_count++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (a.hit !== e.hit) begin
               $display("%0t: hit exp %0d got %0d", $time, e.hit, a.hit); fail_count++;
            end
            if (a.acc !== e.acc) begin
               $display("%0t: access_total exp %0d got %0d", $time, e.acc, a.acc);
               fail_count++;
            end
            if (a.hits !== e.hits) begin
               $display("%0t: hit_total exp %0d got %0d", $time, e.hits, a.hits);
               fail_count++;
            end
            if (a.fetched !== e.fetched) begin
               $display("%0t: bytes_fetched exp %0d got %0d", $time, e.fetched, a.fetched);
               fail_count++;
            end
            if (a.written !== e.written) begin
               $display("%0t: bytes_written exp %0d got %0d", $time, e.written, a.written);
               fail_count++;
            end
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      if (cycles > 1500000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_ASSOC: cfg_assoc = val[1:0];
         REG_WBACK: cfg_wb = val[0];
         REG_BLOG:  cfg_blog = val[3:0];
         default:   cfg_clog = val[4:0];
      endcase
      clear_cache();
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic add_req(op_type op, logic [31:0] addr);
      access_req r;
      r.op = op; r.addr = addr;
      pending_reqs = {pending_reqs, r};
   endtask

   // random address, mostly drawn from a small working set so sets see reuse and eviction
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 4095);
         default: return {$urandom_range(0, 3) == 0 ? 16'hffff : 16'h0,
                          16'($urandom_range(0, 15) << $urandom_range(4, 10))};
      endcase
   endfunction

   task automatic random_phase(int n);
      int k;
      op_type op;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 19);
         op = (k < 10) ? OP_READ : (k < 18) ? OP_WRITE : (k == 18) ? OP_FLUSH : OP_NOP;
         add_req(op, pick_addr());
      end
   endtask

   initial begin
      cfg_assoc = 0; cfg_wb = 1; cfg_blog = 4; cfg_clog = 10;
      clear_cache();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, every op, conflict eviction of dirty lines
      add_req(OP_READ, 32'h0);
      add_req(OP_WRITE, 32'h0);
      add_req(OP_READ, 32'hffff_ffff);
      add_req(OP_WRITE, 32'hffff_ffff);
      add_req(OP_WRITE, 32'h0000_0400);
      add_req(OP_READ, 32'h0000_0000);
      add_req(OP_FLUSH, 32'hdead_beef);
      add_req(OP_NOP, 32'h1234_5678);
      add_req(OP_WRITE, 32'haaaa_aaaa);
      add_req(OP_READ, 32'h5555_5555);
      add_req(OP_FLUSH, 32'h0);
      // hold off new requests until every response is back
      while (pending_reqs.size() > 0) @(posedge clock);
      tx_hold = 1;
      add_req(OP_READ, 32'h0000_0400);
      add_req(OP_WRITE, 32'h0000_0010);
      while (expected_rsps.size() > 0) @(posedge clock);
      tx_hold = 0;
      drain();
      // sweep of settings including extremes and out-of-range values
      write_reg(REG_ASSOC, 1); write_reg(REG_WBACK, 0);
      write_reg(REG_BLOG, 2); write_reg(REG_CLOG, 6);
      add_req(OP_WRITE, 32'h0); add_req(OP_WRITE, 32'h40); add_req(OP_WRITE, 32'h80);
      add_req(OP_READ, 32'h0); add_req(OP_FLUSH, 32'h0);
      random_phase(80); drain();
      write_reg(REG_WBACK, 1); write_reg(REG_ASSOC, 2);
      random_phase(80); drain();
      write_reg(REG_ASSOC, 3); write_reg(REG_CLOG, 8);
      random_phase(80); drain();
      write_reg(REG_BLOG, 8); write_reg(REG_CLOG, 16);
      random_phase(60); drain();
      write_reg(REG_CLOG, 31); write_reg(REG_BLOG, 15); write_reg(REG_ASSOC, 0);
      random_phase(40); drain();
      write_reg(REG_BLOG, 6); write_reg(REG_CLOG, 4); write_reg(REG_ASSOC, 2);
      random_phase(40); drain();
      write_reg(REG_BLOG, 4); write_reg(REG_CLOG, 9); write_reg(REG_ASSOC, 3);
      write_reg(REG_WBACK, 32'hffff_fffe);
      random_phase(80); drain();
      write_reg(REG_ASSOC, 32'hffff_fffd); write_reg(REG_WBACK, 1);
      write_reg(REG_CLOG, 10);
      random_phase(100);
      // tail without idling
      while (pending_reqs.size() > 60) @(posedge clock);
      quiet = 1;
      random_phase(40);
      drain();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

/* files.f */
design/sacl_pkg.sv
design/sacl_line_mem.sv
design/set_assoc_cache_lru_model.sv
dv/tb_top.sv
